// ----- rtl/ega_pkg.sv -----
// Shared types and constants for the embedding gradient accumulator.
`default_nettype none
package ega_pkg;
    localparam int NUM_ROWS_DEF  = 1024;
    localparam int VEC_LEN_DEF   = 64;
    localparam logic [10:0] ROW_COUNT_RST  = 11'd1024;
    localparam logic [6:0]  DIM_IN_USE_RST = 7'd64;
    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
    localparam logic [31:0] FP_ZERO   = 32'h00000000;

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_ROW = 2'd1,
        ERR_COL = 2'd2,
        ERR_NA  = 2'd3
    } err_t;

    typedef enum logic {
        REG_ROW_COUNT  = 1'b0,
        REG_DIM_IN_USE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_ADD, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        FA_IDLE, FA_NORM, FA_ROUND
    } fa_state_t;
endpackage
`default_nettype wire

// ----- rtl/ega_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ega_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/ega_fadd.sv -----
// Multi-cycle binary32 adder, round to nearest even, one-bit-per-cycle normalize.
`default_nettype none
module ega_fadd import ega_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic             done,
    output logic [31:0]      result
);
    fa_state_t   state_reg, state_next;
    logic [26:0] m_reg;
    logic [8:0]  e_reg;
    logic        sign_reg;
    logic        done_reg;
    logic [31:0] res_reg;

    // unpack, align and add
    logic [7:0]  ea, eb, ea1, eb1, eh, el, d;
    logic [22:0] fa, fb;
    logic [26:0] ma, mb, mh, ml, ml_sh, mask;
    logic        sa, sb, sh, sl, swap, special, zero_res;
    logic [27:0] sum;
    logic [26:0] m_new;
    logic [8:0]  e_new;
    logic [31:0] spec_val;

    always_comb begin
        ea = op_a[30:23];
        eb = op_b[30:23];
        fa = op_a[22:0];
        fb = op_b[22:0];
        sa = op_a[31];
        sb = op_b[31];
        ma = {(ea != 8'd0), fa, 3'b000};
        mb = {(eb != 8'd0), fb, 3'b000};
        ea1 = (ea == 8'd0) ? 8'd1 : ea;
        eb1 = (eb == 8'd0) ? 8'd1 : eb;
        swap = (eb1 > ea1) || ((eb1 == ea1) && (mb > ma));
        mh = swap ? mb : ma;
        ml = swap ? ma : mb;
        eh = swap ? eb1 : ea1;
        el = swap ? ea1 : eb1;
        sh = swap ? sb : sa;
        sl = swap ? sa : sb;
        d = eh - el;
        mask = (27'd1 << d[4:0]) - 27'd1;
        if (d >= 8'd27) begin
            ml_sh = {26'd0, (ml != 27'd0)};
        end else begin
            ml_sh = (ml >> d[4:0]) | {26'd0, ((ml & mask) != 27'd0)};
        end
        sum = 28'd0;
        e_new = {1'b0, eh};
        zero_res = 1'b0;
        if (sh == sl) begin
            sum = {1'b0, mh} + {1'b0, ml_sh};
            if (sum[27]) begin
                m_new = sum[27:1] | {26'd0, sum[0]};
                e_new = {1'b0, eh} + 9'd1;
            end else begin
                m_new = sum[26:0];
            end
        end else begin
            m_new = mh - ml_sh;
            zero_res = (m_new == 27'd0);
        end
        // NaN, infinity and exact cancellation
        special = 1'b1;
        if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0)) begin
            spec_val = QNAN_BITS;
        end else if (ea == 8'hFF && eb == 8'hFF) begin
            spec_val = (sa == sb) ? op_a : QNAN_BITS;
        end else if (ea == 8'hFF) begin
            spec_val = op_a;
        end else if (eb == 8'hFF) begin
            spec_val = op_b;
        end else begin
            spec_val = FP_ZERO;
            special = zero_res;
        end
    end

    // rounding
    logic [2:0]  g;
    logic        inc;
    logic [24:0] mr25;
    logic [23:0] mr;
    logic [8:0]  e_rnd;
    logic [31:0] rnd_val;

    always_comb begin
        g = m_reg[2:0];
        inc = (g > 3'd4) || ((g == 3'd4) && m_reg[3]);
        mr25 = {1'b0, m_reg[26:3]} + {24'd0, inc};
        if (mr25[24]) begin
            mr = mr25[24:1];
            e_rnd = e_reg + 9'd1;
        end else begin
            mr = mr25[23:0];
            e_rnd = e_reg;
        end
        if (e_rnd >= 9'd255) begin
            rnd_val = {sign_reg, 8'hFF, 23'd0};
        end else begin
            rnd_val = {sign_reg, (mr[23] ? e_rnd[7:0] : 8'd0), mr[22:0]};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FA_IDLE:  if (start && !special) state_next = FA_NORM;
            FA_NORM:  if (m_reg[26] || e_reg <= 9'd1) state_next = FA_ROUND;
            FA_ROUND: state_next = FA_IDLE;
            default:  state_next = FA_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FA_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == FA_IDLE && start && special) ||
                         (state_reg == FA_ROUND);
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            FA_IDLE: begin
                if (start) begin
                    m_reg    <= m_new;
                    e_reg    <= e_new;
                    sign_reg <= sh;
                    res_reg  <= spec_val;
                end
            end
            FA_NORM: begin
                if (!m_reg[26] && e_reg > 9'd1) begin
                    m_reg <= m_reg << 1;
                    e_reg <= e_reg - 9'd1;
                end
            end
            FA_ROUND: res_reg <= rnd_val;
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

// ----- rtl/embedding_gradient_accumulator.sv -----
// Top level of the embedding gradient accumulator.
// Usage:
// - Input words (s_*) carry a command, a row, a column and a binary32 gradient.
//   Accumulate adds the gradient into the table entry; read returns the entry;
//   read-and-clear returns it and zeroes it. Command 3 behaves as read.
// - Each input word yields one result word (m_*): the entry after the
//   operation (old value for read-and-clear) and an error code. Out-of-range
//   rows or columns give code 1 or 2, value zero, and leave the table alone.
// - Registers row_count (index 0) and dim_in_use (index 1) are written on the
//   cfg_* channel, which is always ready; write them only while idle.
// - One word is in flight at a time. Out-of-range words go from idle to done;
//   reads pass through the read state, accumulates also through the add state.
//   The adder skips normalize and round when an operand is NaN or infinity or
//   the sum cancels exactly; its normalize step shifts one bit per cycle.
// - The next word is taken while a result still waits in the output register;
//   its table write waits until that result is taken.
// - After reset the table is zeroed by a pass over all NUM_ROWS*VEC_LEN words
//   (65536 by default), one word a cycle; s_ready stays low meanwhile.
`default_nettype none
module embedding_gradient_accumulator import ega_pkg::*; #(
    parameter int NUM_ROWS = NUM_ROWS_DEF,
    parameter int VEC_LEN  = VEC_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_row_index,
    input  wire logic [5:0]  s_column_index,
    input  wire logic [31:0] s_grad_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_entry_value,
    output logic [1:0]       m_error_code
);
    localparam int DEPTH = NUM_ROWS * VEC_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t      state_reg, state_next;
    logic [10:0] row_count_reg;
    logic [6:0]  dim_in_use_reg;
    logic [AW:0] clr_cnt_reg;
    cmd_t        cmd_reg;
    err_t        err_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0] grad_reg, val_reg;
    logic        m_valid_reg;
    logic [31:0] m_value_reg;
    err_t        m_err_reg;

    logic        accept, out_free, finish, clr_last, mem_we;
    logic [AW-1:0] s_addr, mem_waddr;
    logic [31:0] mem_wdata, mem_rdata, add_res;
    logic [31:0] addr_full;
    logic        add_start, add_done;
    err_t        s_err;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= ROW_COUNT_RST;
            dim_in_use_reg <= DIM_IN_USE_RST;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                REG_DIM_IN_USE: dim_in_use_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // range check and address of the incoming word
    always_comb begin
        if ({1'b0, s_row_index} >= {6'd0, row_count_reg} ||
            {1'b0, s_row_index} >= 17'(NUM_ROWS)) begin
            s_err = ERR_ROW;
        end else if ({1'b0, s_column_index} >= dim_in_use_reg ||
                     {7'd0, s_column_index} >= 13'(VEC_LEN)) begin
            s_err = ERR_COL;
        end else begin
            s_err = ERR_OK;
        end
        addr_full = {16'd0, s_row_index} * 32'(VEC_LEN) + {26'd0, s_column_index};
        s_addr = addr_full[AW-1:0];
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign clr_last = (clr_cnt_reg == (AW+1)'(DEPTH - 1));
    assign add_start = (state_reg == ST_READ) && (cmd_reg == CMD_ACC);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = (s_err == ERR_OK) ? ST_READ : ST_DONE;
            ST_READ:  state_next = (cmd_reg == CMD_ACC) ? ST_ADD : ST_DONE;
            ST_ADD:   if (add_done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = val_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[AW-1:0];
                mem_wdata = FP_ZERO;
            end
            ST_DONE: begin
                mem_we    = out_free && (err_reg == ERR_OK) &&
                            (cmd_reg == CMD_ACC || cmd_reg == CMD_CLEAR);
                mem_wdata = (cmd_reg == CMD_CLEAR) ? FP_ZERO : val_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // word payload and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_command);
            err_reg  <= s_err;
            addr_reg <= s_addr;
            grad_reg <= s_grad_value;
            val_reg  <= FP_ZERO;
        end
        if (state_reg == ST_READ) begin
            val_reg <= mem_rdata;
        end
        if (state_reg == ST_ADD && add_done) begin
            val_reg <= add_res;
        end
        if (finish) begin
            m_value_reg <= val_reg;
            m_err_reg   <= err_reg;
        end
    end

    ega_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (s_addr),
        .rdata (mem_rdata)
    );

    ega_fadd u_fadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (add_start),
        .op_a    (mem_rdata),
        .op_b    (grad_reg),
        .done    (add_done),
        .result  (add_res)
    );

    assign m_valid       = m_valid_reg;
    assign m_entry_value = m_value_reg;
    assign m_error_code  = m_err_reg;

    // no input word taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("input accepted during clear pass");
    // rejected words report a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |-> m_entry_value == FP_ZERO)
        else $error("error result with nonzero value");
    // rejected words never touch the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && state_reg != ST_CLEAR |-> err_reg == ERR_OK)
        else $error("table written for rejected word");
    // adder finishes only while the controller waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        add_done |-> state_reg == ST_ADD)
        else $error("adder result outside add state");
endmodule
`default_nettype wire
